// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition: %m");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== rtl/core/dcrp_pkg.sv =====
// types and constants of the dhcp client reply parser
`timescale 1ns / 1ps
package dcrp_pkg;

   localparam int unsigned OPTION_AREA_BYTES = 308;
   localparam int unsigned OPT_AREA_FIRST    = 240;
   localparam int unsigned MIN_PACKET_LEN    = OPT_AREA_FIRST + OPTION_AREA_BYTES;
   localparam int unsigned OFFSET_W          = $clog2(MIN_PACKET_LEN + 1);

   localparam logic [OFFSET_W-1:0] OFFSET_MAX       = '1;
   localparam logic [OFFSET_W-1:0] OFF_XID_FIRST    = OFFSET_W'(4);
   localparam logic [OFFSET_W-1:0] OFF_XID_LAST     = OFFSET_W'(7);
   localparam logic [OFFSET_W-1:0] OFF_YIADDR_FIRST = OFFSET_W'(16);
   localparam logic [OFFSET_W-1:0] OFF_YIADDR_LAST  = OFFSET_W'(19);
   localparam logic [OFFSET_W-1:0] OFF_COOKIE_FIRST = OFFSET_W'(236);
   localparam logic [OFFSET_W-1:0] OFF_COOKIE_LAST  = OFFSET_W'(239);
   localparam logic [OFFSET_W-1:0] OFF_AREA_FIRST   = OFFSET_W'(OPT_AREA_FIRST);
   localparam logic [OFFSET_W-1:0] OFF_AREA_END     = OFFSET_W'(MIN_PACKET_LEN);
   localparam logic [OFFSET_W-1:0] OFF_MIN_LAST     = OFFSET_W'(MIN_PACKET_LEN - 1);

   localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
   localparam logic [31:0] DEFAULT_MASK = 32'hFFFF_FF00;
   localparam logic [31:0] XID_RESET    = 32'hBEEF_1234;

   localparam logic [7:0] OPT_PAD      = 8'd0;
   localparam logic [7:0] OPT_SUBNET   = 8'd1;
   localparam logic [7:0] OPT_ROUTER   = 8'd3;
   localparam logic [7:0] OPT_DNS      = 8'd6;
   localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
   localparam logic [7:0] OPT_END      = 8'd255;
   localparam logic [7:0] MSG_OFFER    = 8'd2;
   localparam logic [7:0] MSG_ACK      = 8'd5;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_CODE,
      PH_LENGTH,
      PH_VALUE,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_OFFER,
      CMD_ACK
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ACT_DISCOVER,
      ACT_REQUEST,
      ACT_LEASE
   } action_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  your_ip;
      logic [31:0]  source_ip;
      logic [31:0]  subnet;
      logic [31:0]  router;
      logic [31:0]  dns;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/core/dcrp_front.sv =====
// front end: takes items, walks the reply header and option tlvs, queues commands
`timescale 1ns / 1ps
module dcrp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   input  logic [31:0]            req_source_ip,
   input  logic                   csr_write,
   input  logic [31:0]            csr_transaction_id,
   input  dcrp_pkg::q_status_type q_stat,
   output logic                   q_push,
   output dcrp_pkg::cmd_type      q_push_cmd
);

   logic [31:0]                   xid_ff;
   logic [dcrp_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [31:0]                   shift_ff, shift_in;
   logic                          xid_ok_ff, xid_ok_in;
   logic                          magic_ok_ff, magic_ok_in;
   logic [31:0]                   your_ip_ff, your_ip_in;
   dcrp_pkg::phase_type           phase_ff, phase_in;
   logic [7:0]                    code_ff, code_in;
   logic [7:0]                    remain_ff, remain_in;
   logic [7:0]                    length_ff, length_in;
   logic [31:0]                   acc_ff, acc_in;
   logic [7:0]                    kind_ff, kind_in;
   logic [31:0]                   subnet_ff, subnet_in;
   logic [31:0]                   router_ff, router_in;
   logic [31:0]                   dns_ff, dns_in;

   logic       accept;
   logic       in_area;
   logic [7:0] remain_dec;
   logic [7:0] value_idx;
   logic       reply_ok;

   assign req_stall  = q_stat.full;
   assign accept     = req_valid && !q_stat.full;
   assign in_area    = (offset_ff >= dcrp_pkg::OFF_AREA_FIRST) &&
                       (offset_ff < dcrp_pkg::OFF_AREA_END);
   assign remain_dec = remain_ff - 8'd1;
   assign value_idx  = length_ff - remain_ff;
   assign offset_in  = (offset_ff == dcrp_pkg::OFFSET_MAX) ? offset_ff
                                                           : offset_ff + dcrp_pkg::OFFSET_W'(1);

   // fixed header fields
   always_comb begin
      shift_in    = shift_ff;
      xid_ok_in   = xid_ok_ff;
      magic_ok_in = magic_ok_ff;
      your_ip_in  = your_ip_ff;
      if ((offset_ff >= dcrp_pkg::OFF_XID_FIRST && offset_ff <= dcrp_pkg::OFF_XID_LAST) ||
          (offset_ff >= dcrp_pkg::OFF_COOKIE_FIRST &&
           offset_ff <= dcrp_pkg::OFF_COOKIE_LAST)) begin
         shift_in = {shift_ff[23:0], req_data_byte};
      end
      if (offset_ff == dcrp_pkg::OFF_XID_LAST) begin
         xid_ok_in = (shift_in == xid_ff);
      end
      if (offset_ff == dcrp_pkg::OFF_COOKIE_LAST) begin
         magic_ok_in = (shift_in == dcrp_pkg::MAGIC_COOKIE);
      end
      if (offset_ff >= dcrp_pkg::OFF_YIADDR_FIRST &&
          offset_ff <= dcrp_pkg::OFF_YIADDR_LAST) begin
         your_ip_in = {your_ip_ff[23:0], req_data_byte};
      end
   end

   // option walk next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         dcrp_pkg::PH_CODE: begin
            if (in_area) begin
               if (req_data_byte == dcrp_pkg::OPT_END) begin
                  phase_in = dcrp_pkg::PH_DONE;
               end else if (req_data_byte != dcrp_pkg::OPT_PAD) begin
                  phase_in = dcrp_pkg::PH_LENGTH;
               end
            end
         end
         dcrp_pkg::PH_LENGTH: begin
            phase_in = (req_data_byte != 8'd0) ? dcrp_pkg::PH_VALUE : dcrp_pkg::PH_CODE;
         end
         dcrp_pkg::PH_VALUE: begin
            if (remain_dec == 8'd0) begin
               phase_in = dcrp_pkg::PH_CODE;
            end
         end
         dcrp_pkg::PH_DONE: begin
            phase_in = dcrp_pkg::PH_DONE;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // option walk data
   always_comb begin
      code_in   = code_ff;
      remain_in = remain_ff;
      length_in = length_ff;
      acc_in    = acc_ff;
      kind_in   = kind_ff;
      subnet_in = subnet_ff;
      router_in = router_ff;
      dns_in    = dns_ff;
      unique case (phase_ff)
         dcrp_pkg::PH_CODE: begin
            if (in_area && req_data_byte != dcrp_pkg::OPT_END &&
                req_data_byte != dcrp_pkg::OPT_PAD) begin
               code_in = req_data_byte;
            end
         end
         dcrp_pkg::PH_LENGTH: begin
            length_in = req_data_byte;
            remain_in = req_data_byte;
            acc_in    = '0;
         end
         dcrp_pkg::PH_VALUE: begin
            acc_in    = {acc_ff[23:0], req_data_byte};
            remain_in = remain_dec;
            if (value_idx == 8'd0 && code_ff == dcrp_pkg::OPT_MSG_TYPE &&
                length_ff == 8'd1) begin
               kind_in = req_data_byte;
            end
            if (value_idx == 8'd3) begin
               if (code_ff == dcrp_pkg::OPT_SUBNET && length_ff == 8'd4) begin
                  subnet_in = acc_in;
               end
               if (code_ff == dcrp_pkg::OPT_ROUTER && length_ff >= 8'd4) begin
                  router_in = acc_in;
               end
               if (code_ff == dcrp_pkg::OPT_DNS && length_ff >= 8'd4) begin
                  dns_in = acc_in;
               end
            end
         end
         dcrp_pkg::PH_DONE: begin
            code_in = code_ff;
         end
         default: begin
            code_in = code_ff;
         end
      endcase
   end

   // reply check on the last byte and command out
   assign reply_ok = req_last_byte && (offset_ff >= dcrp_pkg::OFF_MIN_LAST) &&
                     magic_ok_in && xid_ok_in;

   always_comb begin
      q_push               = 1'b0;
      q_push_cmd.kind      = dcrp_pkg::CMD_START;
      q_push_cmd.your_ip   = your_ip_in;
      q_push_cmd.source_ip = req_source_ip;
      q_push_cmd.subnet    = subnet_in;
      q_push_cmd.router    = router_in;
      q_push_cmd.dns       = dns_in;
      if (accept) begin
         if (req_op) begin
            q_push = 1'b1;
         end else if (reply_ok && kind_in == dcrp_pkg::MSG_OFFER) begin
            q_push          = 1'b1;
            q_push_cmd.kind = dcrp_pkg::CMD_OFFER;
         end else if (reply_ok && kind_in == dcrp_pkg::MSG_ACK) begin
            q_push          = 1'b1;
            q_push_cmd.kind = dcrp_pkg::CMD_ACK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xid_ff <= dcrp_pkg::XID_RESET;
      end else if (csr_write) begin
         xid_ff <= csr_transaction_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && (req_op || req_last_byte))) begin
         offset_ff   <= '0;
         shift_ff    <= '0;
         xid_ok_ff   <= 1'b1;
         magic_ok_ff <= 1'b0;
         your_ip_ff  <= '0;
         phase_ff    <= dcrp_pkg::PH_CODE;
         code_ff     <= '0;
         remain_ff   <= '0;
         length_ff   <= '0;
         acc_ff      <= '0;
         kind_ff     <= '0;
         subnet_ff   <= '0;
         router_ff   <= '0;
         dns_ff      <= '0;
      end else if (accept) begin
         offset_ff   <= offset_in;
         shift_ff    <= shift_in;
         xid_ok_ff   <= xid_ok_in;
         magic_ok_ff <= magic_ok_in;
         your_ip_ff  <= your_ip_in;
         phase_ff    <= phase_in;
         code_ff     <= code_in;
         remain_ff   <= remain_in;
         length_ff   <= length_in;
         acc_ff      <= acc_in;
         kind_ff     <= kind_in;
         subnet_ff   <= subnet_in;
         router_ff   <= router_in;
         dns_ff      <= dns_in;
      end
   end

endmodule

// ===== rtl/core/dcrp_queue.sv =====
// short command queue between front and back end
`timescale 1ns / 1ps
module dcrp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dcrp_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output dcrp_pkg::cmd_type      head,
   output dcrp_pkg::q_status_type q_stat
);

   dcrp_pkg::cmd_type             mem_ff [dcrp_pkg::QUEUE_DEPTH];
   logic [dcrp_pkg::QPTR_W-1:0]   wr_ptr_ff;
   logic [dcrp_pkg::QPTR_W-1:0]   rd_ptr_ff;
   logic [dcrp_pkg::QCNT_W-1:0]   count_ff;

   assign head         = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == dcrp_pkg::QCNT_W'(dcrp_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + dcrp_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + dcrp_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + dcrp_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - dcrp_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/core/dcrp_back.sv =====
// back end: client flags and the registered result
`timescale 1ns / 1ps
module dcrp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dcrp_pkg::q_status_type q_stat,
   input  dcrp_pkg::cmd_type      head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_action,
   output logic [31:0]            rsp_client_ip,
   output logic [31:0]            rsp_server_addr,
   output logic [31:0]            rsp_subnet_mask,
   output logic [31:0]            rsp_router_ip,
   output logic [31:0]            rsp_dns_ip
);

   logic                 valid_ff, valid_in;
   logic                 sent_ff, sent_in;
   dcrp_pkg::action_type action_ff, action_in;
   logic [31:0]          client_ff, client_in;
   logic [31:0]          server_ff, server_in;
   logic [31:0]          mask_ff, mask_in;
   logic [31:0]          router_ff, router_in;
   logic [31:0]          dns_ff, dns_in;
   logic                 produce;

   assign pop = !q_stat.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      produce   = 1'b0;
      sent_in   = sent_ff;
      action_in = dcrp_pkg::ACT_DISCOVER;
      client_in = '0;
      server_in = '0;
      mask_in   = '0;
      router_in = '0;
      dns_in    = '0;
      unique case (head.kind)
         dcrp_pkg::CMD_START: begin
            produce = 1'b1;
            sent_in = 1'b0;
         end
         dcrp_pkg::CMD_OFFER: begin
            produce   = !sent_ff;
            sent_in   = 1'b1;
            action_in = dcrp_pkg::ACT_REQUEST;
            client_in = head.your_ip;
            server_in = head.source_ip;
         end
         dcrp_pkg::CMD_ACK: begin
            produce   = 1'b1;
            action_in = dcrp_pkg::ACT_LEASE;
            client_in = head.your_ip;
            mask_in   = (head.subnet != '0) ? head.subnet : dcrp_pkg::DEFAULT_MASK;
            router_in = head.router;
            dns_in    = head.dns;
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   assign valid_in = pop ? produce : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            sent_ff <= sent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && produce) begin
         action_ff <= action_in;
         client_ff <= client_in;
         server_ff <= server_in;
         mask_ff   <= mask_in;
         router_ff <= router_in;
         dns_ff    <= dns_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_client_ip   = client_ff;
   assign rsp_server_addr = server_ff;
   assign rsp_subnet_mask = mask_ff;
   assign rsp_router_ip   = router_ff;
   assign rsp_dns_ip      = dns_ff;

endmodule

// ===== rtl/core/dhcp_client_reply_parser_core.sv =====
// top level of the dhcp client reply parser
`timescale 1ns / 1ps
// Takes one item per clock while req_stall is low: a start, or one byte of a
// received DHCP reply (last_byte marks its end, source_ip is taken with it). A
// start gives a DISCOVER order; a valid OFFER, once per exchange, gives a
// REQUEST order; a valid ACK gives the lease. The front end walks the header
// and option TLVs with a byte counter and a small TLV state machine; a result
// passes through the command queue to the output register. A four-entry
// command queue sits between front and back end; req_stall rises only when
// that queue is full, which happens only while rsp_stall holds results back.
// The transaction ID register is written through csr_valid with csr_ready
// always high, and is meant to change only while the block is idle.
`include "assert_macros.svh"
module dhcp_client_reply_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_source_ip,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [31:0] rsp_client_ip,
   output logic [31:0] rsp_server_addr,
   output logic [31:0] rsp_subnet_mask,
   output logic [31:0] rsp_router_ip,
   output logic [31:0] rsp_dns_ip,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_transaction_id
);

   dcrp_pkg::q_status_type q_stat;
   dcrp_pkg::cmd_type      q_push_cmd;
   dcrp_pkg::cmd_type      q_head;
   logic                   q_push;
   logic                   q_pop;

   assign csr_ready = 1'b1;

   dcrp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_source_ip      (req_source_ip),
      .csr_write          (csr_valid && csr_ready),
      .csr_transaction_id (csr_transaction_id),
      .q_stat             (q_stat),
      .q_push             (q_push),
      .q_push_cmd         (q_push_cmd)
   );

   dcrp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .q_stat   (q_stat)
   );

   dcrp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_client_ip   (rsp_client_ip),
      .rsp_server_addr (rsp_server_addr),
      .rsp_subnet_mask (rsp_subnet_mask),
      .rsp_router_ip   (rsp_router_ip),
      .rsp_dns_ip      (rsp_dns_ip)
   );

   `ASSERT_NEVER(a_queue_overflow, clock, reset, q_push && q_stat.full)
   `ASSERT_PROP(a_start_queued, clock, reset, (req_valid && !req_stall && req_op) |-> q_push)
   `ASSERT_PROP(a_request_fields, clock, reset, (rsp_valid && rsp_action == dcrp_pkg::ACT_REQUEST) |-> (rsp_subnet_mask == '0 && rsp_router_ip == '0 && rsp_dns_ip == '0))
   `ASSERT_PROP(a_no_spurious_rsp, clock, reset, (q_stat.empty && !rsp_valid) |=> !rsp_valid)

endmodule

// ===== test/tb_dhcp_client_reply_parser_core.sv =====
// testbench for the dhcp client reply parser: directed and random items checked against a predictor
`timescale 1ns / 1ps
module tb_dhcp_client_reply_parser_core;

   localparam int unsigned CYCLE_LIMIT = 40_000;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct packed {
      dcrp_pkg::action_type action;
      logic [31:0]          client_ip;
      logic [31:0]          server_addr;
      logic [31:0]          subnet_mask;
      logic [31:0]          router_ip;
      logic [31:0]          dns_ip;
   } order_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic [31:0] req_source_ip = 32'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_action;
   logic [31:0] rsp_client_ip;
   logic [31:0] rsp_server_addr;
   logic [31:0] rsp_subnet_mask;
   logic [31:0] rsp_router_ip;
   logic [31:0] rsp_dns_ip;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_transaction_id = 32'h0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   order_type  expected_orders[$];
   logic [7:0] option_bytes[$];

   // predictor state
   logic [31:0]         xid_reg;
   int unsigned         pk_offset;
   logic [31:0]         pk_shift;
   logic                pk_xid_ok;
   logic                pk_magic_ok;
   logic [31:0]         pk_yiaddr;
   dcrp_pkg::phase_type pk_phase;
   logic [7:0]          pk_code;
   logic [7:0]          pk_remaining;
   logic [7:0]          pk_length;
   logic [31:0]         pk_accum;
   logic [7:0]          pk_msg;
   logic [31:0]         pk_subnet;
   logic [31:0]         pk_router;
   logic [31:0]         pk_dns;
   logic                requested;
   logic                leased;
   logic [31:0]         offer_ip;
   logic [31:0]         offer_srv;

   dhcp_client_reply_parser_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_source_ip      (req_source_ip),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_action         (rsp_action),
      .rsp_client_ip      (rsp_client_ip),
      .rsp_server_addr    (rsp_server_addr),
      .rsp_subnet_mask    (rsp_subnet_mask),
      .rsp_router_ip      (rsp_router_ip),
      .rsp_dns_ip         (rsp_dns_ip),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_transaction_id (csr_transaction_id)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 50)
         $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
   endtask

   always @(posedge clock) begin : check_results
      order_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_orders.size() == 0) begin
            report_mismatch("unexpected result, action", 32'(rsp_action), 32'h0);
         end else begin
            want = expected_orders.pop_front();
            if (rsp_action !== want.action)
               report_mismatch("action", 32'(rsp_action), 32'(want.action));
            if (rsp_client_ip !== want.client_ip)
               report_mismatch("client_ip", rsp_client_ip, want.client_ip);
            if (rsp_server_addr !== want.server_addr)
               report_mismatch("server_addr", rsp_server_addr, want.server_addr);
            if (rsp_subnet_mask !== want.subnet_mask)
               report_mismatch("subnet_mask", rsp_subnet_mask, want.subnet_mask);
            if (rsp_router_ip !== want.router_ip)
               report_mismatch("router_ip", rsp_router_ip, want.router_ip);
            if (rsp_dns_ip !== want.dns_ip)
               report_mismatch("dns_ip", rsp_dns_ip, want.dns_ip);
         end
      end
   end

   task automatic clear_reply_state();
      pk_offset = 0;
      pk_shift = '0;
      pk_xid_ok = 1'b1;
      pk_magic_ok = 1'b0;
      pk_yiaddr = '0;
      pk_phase = dcrp_pkg::PH_CODE;
      pk_code = '0;
      pk_remaining = '0;
      pk_length = '0;
      pk_accum = '0;
      pk_msg = '0;
      pk_subnet = '0;
      pk_router = '0;
      pk_dns = '0;
   endtask

   task automatic predict_item(input logic op, input logic [7:0] b, input logic last,
                               input logic [31:0] src);
      order_type   o;
      int unsigned off;
      logic [7:0]  idx;
      o = '0;
      if (op) begin
         clear_reply_state();
         requested = 1'b0;
         leased = 1'b0;
         offer_ip = '0;
         offer_srv = '0;
         o.action = dcrp_pkg::ACT_DISCOVER;
         expected_orders.push_back(o);
      end else begin
         off = pk_offset;
         if (off >= 4 && off <= 7) begin
            pk_shift = {pk_shift[23:0], b};
            if (off == 7) pk_xid_ok = (pk_shift == xid_reg);
         end
         if (off >= 16 && off <= 19) pk_yiaddr = {pk_yiaddr[23:0], b};
         if (off >= 236 && off <= 239) begin
            pk_shift = {pk_shift[23:0], b};
            if (off == 239) pk_magic_ok = (pk_shift == dcrp_pkg::MAGIC_COOKIE);
         end
         case (pk_phase)
            dcrp_pkg::PH_CODE: begin
               if (off >= dcrp_pkg::OPT_AREA_FIRST && off < dcrp_pkg::MIN_PACKET_LEN) begin
                  if (b == dcrp_pkg::OPT_END) begin
                     pk_phase = dcrp_pkg::PH_DONE;
                  end else if (b != dcrp_pkg::OPT_PAD) begin
                     pk_code = b;
                     pk_phase = dcrp_pkg::PH_LENGTH;
                  end
               end
            end
            dcrp_pkg::PH_LENGTH: begin
               pk_length = b;
               pk_remaining = b;
               pk_accum = '0;
               pk_phase = (b != 8'h00) ? dcrp_pkg::PH_VALUE : dcrp_pkg::PH_CODE;
            end
            dcrp_pkg::PH_VALUE: begin
               idx = pk_length - pk_remaining;
               pk_accum = {pk_accum[23:0], b};
               if (idx == 0 && pk_code == dcrp_pkg::OPT_MSG_TYPE && pk_length == 1)
                  pk_msg = b;
               if (idx == 3) begin
                  if (pk_code == dcrp_pkg::OPT_SUBNET && pk_length == 4) pk_subnet = pk_accum;
                  if (pk_code == dcrp_pkg::OPT_ROUTER && pk_length >= 4) pk_router = pk_accum;
                  if (pk_code == dcrp_pkg::OPT_DNS && pk_length >= 4) pk_dns = pk_accum;
               end
               pk_remaining = pk_remaining - 8'd1;
               if (pk_remaining == 0) pk_phase = dcrp_pkg::PH_CODE;
            end
            default: ;
         endcase
         // byte counter saturates
         if (pk_offset < 32'hFFFF) pk_offset++;
         if (last) begin
            if (off + 1 >= dcrp_pkg::MIN_PACKET_LEN && pk_magic_ok && pk_xid_ok) begin
               if (pk_msg == dcrp_pkg::MSG_OFFER) begin
                  if (!requested) begin
                     offer_ip = pk_yiaddr;
                     offer_srv = src;
                     requested = 1'b1;
                     o.action = dcrp_pkg::ACT_REQUEST;
                     o.client_ip = offer_ip;
                     o.server_addr = offer_srv;
                     expected_orders.push_back(o);
                  end
               end else if (pk_msg == dcrp_pkg::MSG_ACK) begin
                  leased = 1'b1;
                  o.action = dcrp_pkg::ACT_LEASE;
                  o.client_ip = pk_yiaddr;
                  o.subnet_mask = (pk_subnet != 0) ? pk_subnet : dcrp_pkg::DEFAULT_MASK;
                  o.router_ip = pk_router;
                  o.dns_ip = pk_dns;
                  expected_orders.push_back(o);
               end
            end
            clear_reply_state();
         end
      end
   endtask

   task automatic send_item(input logic op, input logic [7:0] data, input logic last,
                            input logic [31:0] src);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_data_byte = data;
      req_last_byte = last;
      req_source_ip = src;
      do @(posedge clock); while (req_stall);
      predict_item(op, data, last, src);
   endtask

   task automatic send_start();
      send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), $urandom());
   endtask

   task automatic add_option(input logic [7:0] code, input int unsigned len,
                             input logic [31:0] value);
      option_bytes.push_back(code);
      option_bytes.push_back(8'(len));
      for (int unsigned k = 0; k < len; k++) begin
         if (k < 4) option_bytes.push_back(value[8*(3-k) +: 8]);
         else option_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic pad_options_to(input int unsigned offset);
      while (dcrp_pkg::OPT_AREA_FIRST + option_bytes.size() < offset)
         option_bytes.push_back(dcrp_pkg::OPT_PAD);
   endtask

   // header fields in place, queued options from the area start, random fill after
   task automatic send_reply(input logic [31:0] xid, input logic [31:0] cookie,
                             input logic [31:0] yiaddr, input logic [31:0] src,
                             input int unsigned total_len);
      logic [7:0] b;
      for (int unsigned i = 0; i < total_len; i++) begin
         if (i >= 4 && i <= 7) b = xid[8*(7-i) +: 8];
         else if (i >= 16 && i <= 19) b = yiaddr[8*(19-i) +: 8];
         else if (i >= 236 && i <= 239) b = cookie[8*(239-i) +: 8];
         else if (i >= dcrp_pkg::OPT_AREA_FIRST &&
                  i - dcrp_pkg::OPT_AREA_FIRST < option_bytes.size())
            b = option_bytes[i - dcrp_pkg::OPT_AREA_FIRST];
         else b = 8'($urandom_range(255));
         if (i == total_len - 1) send_item(1'b0, b, 1'b1, src);
         else send_item(1'b0, b, 1'b0, $urandom());
      end
      option_bytes.delete();
   endtask

   task automatic drain_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_orders.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_xid(input logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_transaction_id = value;
      do @(posedge clock); while (!csr_ready);
      xid_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_start_order();
      send_item(1'b1, 8'h00, 1'b0, 32'h0000_0000);
      send_item(1'b1, 8'hFF, 1'b1, 32'hFFFF_FFFF);
      drain_block();
   endtask

   task automatic test_offer_and_ack();
      // replies must carry the newly written id
      write_xid(32'h5A5A_0F0F);
      send_start();
      // offer, with options after end ignored
      add_option(dcrp_pkg::OPT_MSG_TYPE, 1, {dcrp_pkg::MSG_OFFER, 24'h0});
      add_option(dcrp_pkg::OPT_SUBNET, 4, 32'hFFFF_FF80);
      option_bytes.push_back(dcrp_pkg::OPT_END);
      add_option(dcrp_pkg::OPT_MSG_TYPE, 1, {dcrp_pkg::MSG_ACK, 24'h0});
      send_reply(xid_reg, dcrp_pkg::MAGIC_COOKIE, 32'hC0A8_010A, 32'hFFFF_FFFF,
                 dcrp_pkg::MIN_PACKET_LEN);
      // ack: zero mask, wrong lengths, duplicates, option running past the area
      option_bytes.push_back(dcrp_pkg::OPT_PAD);
      add_option(dcrp_pkg::OPT_MSG_TYPE, 1, {dcrp_pkg::MSG_ACK, 24'h0});
      add_option(dcrp_pkg::OPT_MSG_TYPE, 2, {dcrp_pkg::MSG_OFFER, dcrp_pkg::MSG_OFFER, 16'h0});
      add_option(dcrp_pkg::OPT_SUBNET, 4, 32'h0);
      add_option(dcrp_pkg::OPT_SUBNET, 5, 32'h1122_3344);
      add_option(dcrp_pkg::OPT_ROUTER, 6, 32'h0A0A_0A01);
      add_option(dcrp_pkg::OPT_ROUTER, 4, 32'h0A0A_0A02);
      add_option(dcrp_pkg::OPT_DNS, 8, 32'h0808_0808);
      add_option(8'd200, 3, 32'hDEAD_BEEF);
      pad_options_to(dcrp_pkg::MIN_PACKET_LEN - 2);
      add_option(dcrp_pkg::OPT_DNS, 4, 32'h0808_0404);
      send_reply(xid_reg, dcrp_pkg::MAGIC_COOKIE, 32'h0A0A_0A64, $urandom(),
                 dcrp_pkg::MIN_PACKET_LEN + 4);
      drain_block();
   endtask

   task automatic test_dropped_replies();
      send_start();
      send_item(1'b0, 8'($urandom_range(255)), 1'b1, $urandom());
      send_reply(xid_reg, dcrp_pkg::MAGIC_COOKIE, 32'h0A00_0002, 32'h0A00_0001, 8);
      send_reply(xid_reg, dcrp_pkg::MAGIC_COOKIE, 32'h0A00_0003, 32'h0A00_0001, 20);
      drain_block();
   endtask

   task automatic test_start_mid_packet();
      repeat (10) send_item(1'b0, 8'($urandom_range(255)), 1'b0, $urandom());
      send_start();
      send_reply(xid_reg, dcrp_pkg::MAGIC_COOKIE, 32'h0B00_0007, 32'h0B00_0001, 6);
      drain_block();
   endtask

   task automatic random_sequence();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(2);
      n = $urandom_range(1, 5);
      case (pick)
         0: repeat (n) send_start();
         1: for (int unsigned i = 0; i < n; i++)
               send_item(1'b0, 8'($urandom_range(255)), i == n - 1, $urandom());
         default: begin
            repeat (n) send_item(1'b0, 8'($urandom_range(255)), 1'b0, $urandom());
            send_start();
         end
      endcase
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < 4; ph++) begin
         write_xid($urandom());
         case (ph)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 82; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 82; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         repeat (6) random_sequence();
         drain_block();
      end
   endtask

   initial begin
      xid_reg = dcrp_pkg::XID_RESET;
      clear_reply_state();
      requested = 1'b0;
      leased = 1'b0;
      offer_ip = '0;
      offer_srv = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_start_order();
      test_offer_and_ack();
      test_dropped_replies();
      test_start_mid_packet();
      test_random_traffic();
      drain_block();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
